// ===== rtl/core/hdu_pkg.sv =====
// ----------------------------------------------------------------------------
// hdu_pkg
// Shared types and constants for the half-duplex 8N1 serial port.
// ----------------------------------------------------------------------------
`default_nettype none

package hdu_pkg;

   // Configuration register file
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 16;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;

   localparam csr_index_type CSR_BIT_TICKS          = 1'b0;
   localparam csr_index_type CSR_FIRST_SAMPLE_TICKS = 1'b1;

   localparam csr_data_type BIT_TICKS_RESET          = 16'd104;
   localparam csr_data_type FIRST_SAMPLE_TICKS_RESET = 16'd156;

   // Frame layout: eight data bits, then the stop slot
   typedef logic [3:0] bit_count_type;
   localparam bit_count_type DATA_BITS = 4'd8;
   localparam bit_count_type STOP_SLOT = 4'd9;

   typedef logic [15:0] tick_type;

   // Port mode
   typedef enum logic [2:0] {
      MODE_IDLE = 3'b001,
      MODE_TX   = 3'b010,
      MODE_RX   = 3'b100
   } mode_type;

   // One request: one line tick
   typedef struct packed {
      logic       cmd;
      logic       line_in;
      logic [7:0] tx_byte;
   } req_type;

   // One result: port status after the tick
   typedef struct packed {
      logic       line_out;
      logic       line_drive;
      logic       tx_busy;
      logic       rx_busy;
      logic       rx_valid;
      logic [7:0] rx_byte;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/hdu_if.sv =====
// ----------------------------------------------------------------------------
// hdu_req_if / hdu_rsp_if
// Valid/ready channels for line tick requests and port status results.
// ----------------------------------------------------------------------------
`default_nettype none

interface hdu_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic       line_in;
   logic [7:0] tx_byte;

   modport source (output valid, output cmd, output line_in, output tx_byte, input ready);
   modport sink   (input valid, input cmd, input line_in, input tx_byte, output ready);
endinterface

interface hdu_rsp_if;
   logic       valid;
   logic       ready;
   logic       line_out;
   logic       line_drive;
   logic       tx_busy;
   logic       rx_busy;
   logic       rx_valid;
   logic [7:0] rx_byte;

   modport source (output valid, output line_out, output line_drive, output tx_busy,
                   output rx_busy, output rx_valid, output rx_byte, input ready);
   modport sink   (input valid, input line_out, input line_drive, input tx_busy,
                   input rx_busy, input rx_valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hdu_in_reg.sv =====
// ----------------------------------------------------------------------------
// hdu_in_reg
// Input register: captures one request and holds it until the step logic
// consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hdu_in_reg (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire hdu_pkg::req_type in_data,
   output logic                 out_valid,
   input  wire logic            out_take,
   output hdu_pkg::req_type     out_data
);

   logic             valid_ff, valid_in;
   hdu_pkg::req_type data_ff;
   logic             accept;

   // Free when empty or when the held request leaves this cycle
   assign in_ready = !valid_ff || out_take;
   assign accept   = in_valid && in_ready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (out_take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load payload on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/hdu_step.sv =====
// ----------------------------------------------------------------------------
// hdu_step
// Port state and configuration registers; advances the transmitter or
// receiver by one tick per request and forms the status result.
// ----------------------------------------------------------------------------
`default_nettype none

module hdu_step (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire hdu_pkg::csr_index_type csr_index,
   input  wire hdu_pkg::csr_data_type  csr_wdata,
   input  wire logic                  step_fire,
   input  wire hdu_pkg::req_type       step_req,
   output hdu_pkg::rsp_type            step_rsp
);

   hdu_pkg::csr_data_type  bit_ticks_ff, first_sample_ticks_ff;
   hdu_pkg::mode_type      mode_ff, mode_in;
   hdu_pkg::tick_type      tick_count_ff, tick_count_in;
   hdu_pkg::bit_count_type bit_count_ff, bit_count_in;
   logic [7:0]             send_shift_ff, send_shift_in;
   logic [7:0]             receive_shift_ff, receive_shift_in;
   logic                   drive_level_ff, drive_level_in;

   hdu_pkg::tick_type      tick_inc;
   hdu_pkg::tick_type      bit_period;
   hdu_pkg::tick_type      first_period;
   hdu_pkg::tick_type      rx_target;
   logic                   rx_valid;
   logic                   tx_now;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ticks_ff          <= hdu_pkg::BIT_TICKS_RESET;
         first_sample_ticks_ff <= hdu_pkg::FIRST_SAMPLE_TICKS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            hdu_pkg::CSR_BIT_TICKS:          bit_ticks_ff          <= csr_wdata;
            hdu_pkg::CSR_FIRST_SAMPLE_TICKS: first_sample_ticks_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A period of zero behaves as one tick
   assign bit_period   = (bit_ticks_ff == '0) ? 16'd1 : bit_ticks_ff;
   assign first_period = (first_sample_ticks_ff == '0) ? 16'd1 : first_sample_ticks_ff;
   assign rx_target    = (bit_count_ff == '0) ? first_period : bit_period;
   assign tick_inc     = tick_count_ff + 16'd1;

   // Advance the port by one tick
   always_comb begin
      mode_in          = mode_ff;
      tick_count_in    = tick_count_ff;
      bit_count_in     = bit_count_ff;
      send_shift_in    = send_shift_ff;
      receive_shift_in = receive_shift_ff;
      drive_level_in   = drive_level_ff;
      rx_valid         = 1'b0;
      case (mode_ff)
         hdu_pkg::MODE_TX: begin
            if (tick_inc >= bit_period) begin
               tick_count_in = '0;
               if (bit_count_ff < hdu_pkg::DATA_BITS) begin
                  drive_level_in = send_shift_ff[0];
                  send_shift_in  = {1'b0, send_shift_ff[7:1]};
                  bit_count_in   = bit_count_ff + 4'd1;
               end else if (bit_count_ff == hdu_pkg::DATA_BITS) begin
                  drive_level_in = 1'b1;
                  bit_count_in   = hdu_pkg::STOP_SLOT;
               end else begin
                  drive_level_in = 1'b1;
                  bit_count_in   = '0;
                  mode_in        = hdu_pkg::MODE_IDLE;
               end
            end else begin
               tick_count_in = tick_inc;
            end
         end
         hdu_pkg::MODE_RX: begin
            if (tick_inc >= rx_target) begin
               tick_count_in = '0;
               if (bit_count_ff < hdu_pkg::DATA_BITS) begin
                  receive_shift_in = {step_req.line_in, receive_shift_ff[7:1]};
                  bit_count_in     = bit_count_ff + 4'd1;
               end else begin
                  rx_valid     = 1'b1;
                  bit_count_in = '0;
                  mode_in      = hdu_pkg::MODE_IDLE;
               end
            end else begin
               tick_count_in = tick_inc;
            end
         end
         default: begin
            // Idle: a send request wins over a start edge
            mode_in = hdu_pkg::MODE_IDLE;
            if (step_req.cmd) begin
               mode_in        = hdu_pkg::MODE_TX;
               send_shift_in  = step_req.tx_byte;
               drive_level_in = 1'b0;
               tick_count_in  = '0;
               bit_count_in   = '0;
            end else if (!step_req.line_in) begin
               mode_in       = hdu_pkg::MODE_RX;
               tick_count_in = '0;
               bit_count_in  = '0;
            end
         end
      endcase
   end

   // Status after the tick
   assign tx_now              = (mode_in == hdu_pkg::MODE_TX);
   assign step_rsp.line_out   = tx_now ? drive_level_in : 1'b1;
   assign step_rsp.line_drive = tx_now;
   assign step_rsp.tx_busy    = tx_now;
   assign step_rsp.rx_busy    = (mode_in == hdu_pkg::MODE_RX);
   assign step_rsp.rx_valid   = rx_valid;
   assign step_rsp.rx_byte    = rx_valid ? receive_shift_ff : 8'd0;

   // Commit state when a request is consumed
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= hdu_pkg::MODE_IDLE;
         tick_count_ff    <= '0;
         bit_count_ff     <= '0;
         send_shift_ff    <= '0;
         receive_shift_ff <= '0;
         drive_level_ff   <= 1'b1;
      end else if (step_fire) begin
         mode_ff          <= mode_in;
         tick_count_ff    <= tick_count_in;
         bit_count_ff     <= bit_count_in;
         send_shift_ff    <= send_shift_in;
         receive_shift_ff <= receive_shift_in;
         drive_level_ff   <= drive_level_in;
      end
   end

   // Counters stay inside the frame
   a_tx_bit_range: assert property (@(posedge clock) disable iff (reset)
      mode_ff == hdu_pkg::MODE_TX |-> bit_count_ff <= hdu_pkg::STOP_SLOT)
      else $error("transmit bit counter past stop slot");

   a_rx_bit_range: assert property (@(posedge clock) disable iff (reset)
      mode_ff == hdu_pkg::MODE_RX |-> bit_count_ff <= hdu_pkg::DATA_BITS)
      else $error("receive bit counter past last data bit");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      mode_ff == hdu_pkg::MODE_IDLE |-> bit_count_ff == '0 && tick_count_ff == '0)
      else $error("idle port with live counters");

   a_rx_done_src: assert property (@(posedge clock) disable iff (reset)
      step_fire && rx_valid |=> mode_ff == hdu_pkg::MODE_IDLE)
      else $error("receive completion did not return to idle");

endmodule

`default_nettype wire

// ===== rtl/core/hdu_out_reg.sv =====
// ----------------------------------------------------------------------------
// hdu_out_reg
// Result register: holds one status result until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hdu_out_reg (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            load,
   input  wire hdu_pkg::rsp_type load_data,
   output logic                 space,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output hdu_pkg::rsp_type     out_data
);

   logic             valid_ff, valid_in;
   hdu_pkg::rsp_type data_ff;

   // Room when empty or when the held result is taken now
   assign space = !valid_ff || out_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/half_duplex_uart_8n1.sv =====
// ----------------------------------------------------------------------------
// half_duplex_uart_8n1
// Half-duplex 8N1 serial port on one shared line, one line tick per request.
// ----------------------------------------------------------------------------
// Each request is one oversampling tick carrying the sampled line level and an
// optional byte to send (taken only when the port is idle); each request gives
// exactly one result with the line drive and status after that tick. A request
// is taken when the input register is empty or its held request moves on; it
// passes through the input register, then the combinational state update, into
// the result register; one request per clock is sustained unless the result
// side stalls, and such stalls hold the request side without losing ticks. Write
// bit_ticks and first_sample_ticks only while no request is in flight; a new
// value takes effect at once, even in the middle of a frame.
`default_nettype none

module half_duplex_uart_8n1 (
   input  wire logic                   clock,
   input  wire logic                   reset,
   hdu_req_if.sink                     req,
   hdu_rsp_if.source                   rsp,
   input  wire logic                   csr_we,
   input  wire hdu_pkg::csr_index_type csr_index,
   input  wire hdu_pkg::csr_data_type  csr_wdata
);

   hdu_pkg::req_type req_data, held_req;
   hdu_pkg::rsp_type step_rsp, out_rsp;
   logic             held_valid;
   logic             out_space;
   logic             advance;

   assign req_data.cmd     = req.cmd;
   assign req_data.line_in = req.line_in;
   assign req_data.tx_byte = req.tx_byte;

   // Move a held request through the step when the result register has room
   assign advance = held_valid && out_space;

   hdu_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_data   (req_data),
      .out_valid (held_valid),
      .out_take  (advance),
      .out_data  (held_req)
   );

   hdu_step u_step (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step_fire (advance),
      .step_req  (held_req),
      .step_rsp  (step_rsp)
   );

   hdu_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_data (step_rsp),
      .space     (out_space),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (out_rsp)
   );

   assign rsp.line_out   = out_rsp.line_out;
   assign rsp.line_drive = out_rsp.line_drive;
   assign rsp.tx_busy    = out_rsp.tx_busy;
   assign rsp.rx_busy    = out_rsp.rx_busy;
   assign rsp.rx_valid   = out_rsp.rx_valid;
   assign rsp.rx_byte    = out_rsp.rx_byte;

endmodule

`default_nettype wire
